/* design/sfc_pkg.sv */
// ---------------------------------------------------------------------------
// sfc_pkg: shared types and constants of the sync marker frame capture
// Marker bytes, status codes, matcher stages and default sizes.
// ---------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

    // Default payload capacity of one buffer in bytes.
    localparam int SFC_FRAME_BYTES = 1024;

    // Length of the marker "SYNC" in bytes.
    localparam int SFC_MARK_LEN = 4;

    // Marker characters.
    localparam logic [7:0] SYM_S = 8'h53;
    localparam logic [7:0] SYM_Y = 8'h59;
    localparam logic [7:0] SYM_N = 8'h4E;
    localparam logic [7:0] SYM_C = 8'h43;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_START     = 3'd1,
        ST_FRAME     = 3'd2,
        ST_SHORT     = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    // Item kinds on the input tuser.
    typedef enum logic {
        REQ_RX   = 1'b0,
        REQ_READ = 1'b1
    } t_req;

    // How much of the marker has been seen so far.
    typedef enum logic [1:0] {
        M_IDLE = 2'd0,
        M_S    = 2'd1,
        M_SY   = 2'd2,
        M_SYN  = 2'd3
    } t_match;

endpackage

`default_nettype wire

/* design/sync_marker_frame_capture.sv */
// ---------------------------------------------------------------------------
// sync_marker_frame_capture: byte-stream deframer with ping-pong buffers
// Finds the marker "SYNC", captures the bytes between markers into one of
// two buffers, reports each frame and answers reads of stored bytes.
// ---------------------------------------------------------------------------
//
//  Channel   Dir  tuser              tdata
//  s_axis    in   req_type           rx_byte, hold_first, hold_second,
//                                    read_buffer, read_index
//  m_axis    out  status             frame_buffer, frame_length, read_data,
//                                    active_buffer
//
// One item is accepted per cycle unless a stalled output backs up into
// s_axis_tready. Its result passes through the pipeline slot, which waits on
// the frame store read (registered RAM output), and then the output register.
// Matcher and capture state update in the cycle of acceptance. Reset clears
// the matcher, the capture state and both pipeline slots, not the frame store.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_marker_frame_capture
    import sfc_pkg::*;
#(
    parameter int FRAME_BYTES = SFC_FRAME_BYTES,
    localparam int SPAN    = FRAME_BYTES + SFC_MARK_LEN,
    localparam int IDX_W   = $clog2(SPAN + 1),
    localparam int LEN_W   = $clog2(FRAME_BYTES + 1),
    localparam int IN_DW   = ((11 + IDX_W + 7) / 8) * 8,
    localparam int OUT_DW  = ((10 + LEN_W + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: rx_byte[7:0], hold_first, hold_second, read_buffer, read_index
    input  wire logic [IN_DW-1:0]  s_axis_tdata,
    // tuser: req_type
    input  wire logic              s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // tdata: frame_buffer, frame_length, read_data[7:0], active_buffer
    output logic [OUT_DW-1:0]      m_axis_tdata,
    // tuser: status[2:0]
    output logic [2:0]             m_axis_tuser
);

    localparam int ADDR_W = $clog2(2 * SPAN);
    localparam int FILL_W = LEN_W;

    // Input fields.
    logic [7:0]       rx_byte;
    logic             hold_first;
    logic             hold_second;
    logic             read_buffer;
    logic [IDX_W-1:0] read_index;
    t_req             req_type;

    assign rx_byte     = s_axis_tdata[7:0];
    assign hold_first  = s_axis_tdata[8];
    assign hold_second = s_axis_tdata[9];
    assign read_buffer = s_axis_tdata[10];
    assign read_index  = s_axis_tdata[11 +: IDX_W];
    assign req_type    = t_req'(s_axis_tuser);

    // State.
    t_match            r_match,     n_match;
    logic              r_capturing, n_capturing;
    logic [FILL_W-1:0] r_fill,      n_fill;
    logic              r_active,    n_active;

    // Pipeline slot that waits on the RAM read, and the output register.
    logic              r_s1_vld;
    t_status           r_s1_status, n_s1_status;
    logic              r_s1_fbuf,   n_s1_fbuf;
    logic [LEN_W-1:0]  r_s1_flen,   n_s1_flen;
    logic              r_s1_rd_use, n_s1_rd_use;
    logic              r_s1_active;

    logic              r_out_vld;
    t_status           r_out_status;
    logic              r_out_fbuf;
    logic [LEN_W-1:0]  r_out_flen;
    logic [7:0]        r_out_rdata;
    logic              r_out_active;

    logic              s1_move;
    logic              accept;
    logic              match_hit;
    t_match            match_adv;
    logic              held;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    assign s1_move       = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || s1_move;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Marker matcher: 'S' always restarts, others advance only in order.
    always_comb begin
        match_hit = 1'b0;
        if (rx_byte == SYM_S) begin
            match_adv = M_S;
        end else if (rx_byte == SYM_Y && r_match == M_S) begin
            match_adv = M_SY;
        end else if (rx_byte == SYM_N && r_match == M_SY) begin
            match_adv = M_SYN;
        end else if (rx_byte == SYM_C && r_match == M_SYN) begin
            match_adv = M_IDLE;
            match_hit = 1'b1;
        end else begin
            match_adv = M_IDLE;
        end
    end

    assign held = r_active ? hold_second : hold_first;

    // Capture control, frame store write and read request.
    always_comb begin
        n_match     = r_match;
        n_capturing = r_capturing;
        n_fill      = r_fill;
        n_active    = r_active;
        n_s1_status = ST_NONE;
        n_s1_fbuf   = 1'b0;
        n_s1_flen   = '0;
        n_s1_rd_use = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = r_active ? ADDR_W'(SPAN) + ADDR_W'(r_fill) : ADDR_W'(r_fill);
        ram_raddr   = read_buffer ? ADDR_W'(SPAN) + ADDR_W'(read_index)
                                  : ADDR_W'(read_index);

        if (accept) begin
            if (req_type == REQ_READ) begin
                if (read_index < IDX_W'(SPAN)) begin
                    ram_re      = 1'b1;
                    n_s1_rd_use = 1'b1;
                end
            end else begin
                n_match = match_adv;
                if (r_capturing && !held) begin
                    // The byte at full capacity lands in the slack entry.
                    ram_we = 1'b1;
                    if (r_fill == FILL_W'(FRAME_BYTES)) begin
                        n_capturing = 1'b0;
                        n_fill      = '0;
                        n_s1_status = ST_OVERFLOW;
                    end else if (match_hit) begin
                        n_fill = '0;
                        if (r_fill >= FILL_W'(SFC_MARK_LEN)) begin
                            n_s1_status = ST_FRAME;
                            n_s1_fbuf   = r_active;
                            n_s1_flen   = r_fill - FILL_W'(SFC_MARK_LEN - 1);
                            n_active    = !r_active;
                        end else begin
                            n_s1_status = ST_SHORT;
                            n_capturing = 1'b0;
                        end
                    end else begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                end else if (match_hit && !r_capturing) begin
                    n_capturing = 1'b1;
                    n_fill      = '0;
                    n_s1_status = ST_START;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match     <= M_IDLE;
            r_capturing <= 1'b0;
            r_fill      <= '0;
            r_active    <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_match     <= n_match;
            r_capturing <= n_capturing;
            r_fill      <= n_fill;
            r_active    <= n_active;
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= n_s1_status;
            r_s1_fbuf   <= n_s1_fbuf;
            r_s1_flen   <= n_s1_flen;
            r_s1_rd_use <= n_s1_rd_use;
            r_s1_active <= n_active;
        end
        if (s1_move) begin
            r_out_status <= r_s1_status;
            r_out_fbuf   <= r_s1_fbuf;
            r_out_flen   <= r_s1_flen;
            r_out_rdata  <= r_s1_rd_use ? ram_rdata : 8'd0;
            r_out_active <= r_s1_active;
        end
    end

    sfc_ram #(
        .WIDTH (8),
        .DEPTH (2 * SPAN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (rx_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = OUT_DW'({r_out_active, r_out_rdata, r_out_flen, r_out_fbuf});

    // Fill count never passes the buffer capacity.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(FRAME_BYTES))
        else $error("fill count beyond capacity");

    // Outside capture the fill count rests at zero.
    a_fill_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_capturing |-> r_fill == '0)
        else $error("fill count not cleared outside capture");

    // A full pipeline with a stalled consumer takes no new item.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && r_out_vld && !m_axis_tready |-> !s_axis_tready)
        else $error("item accepted while pipeline is blocked");

    // A completed frame always carries payload.
    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_status == ST_FRAME |-> r_out_flen != '0)
        else $error("completed frame with zero length");

    // A frame report swaps the active buffer.
    a_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && n_s1_status == ST_FRAME |=> r_active != $past(r_active))
        else $error("buffer not swapped after frame");

endmodule

`default_nettype wire

/* design/sfc_ram.sv */
// ---------------------------------------------------------------------------
// sfc_ram: generic single-clock RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module sfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2056
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data changes only on a read, so it holds while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
